### sv/pdq_pkg.sv
package pdq_pkg;

    localparam int NUM_READERS  = 2;
    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 16;

    localparam int NUM_ENTRIES = NUM_READERS * QUEUE_DEPTH;
    localparam int CH_W        = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // transaction field widths
    localparam int CMD_W     = 3;
    localparam int READER_W  = 8;
    localparam int HND_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    // only the low HANDLE_WIDTH bits of a handle are kept
    localparam logic [HND_W-1:0] HANDLE_MASK = HND_W'((64'd1 << HANDLE_WIDTH) - 64'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP        = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_BADCH = 3'd2,
        STAT_EMPTY = 3'd3,
        STAT_NULL  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more;
        logic out_free;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(p) + 1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : PTR_W'(int'(p) - 1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        int sum;
        sum = int'(p) + int'(n);
        if (sum >= QUEUE_DEPTH) begin
            sum = sum - QUEUE_DEPTH;
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(int'(ch) * QUEUE_DEPTH + int'(p));
    endfunction

endpackage

### sv/pdq_if.sv
interface pdq_in_if import pdq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [READER_W-1:0] reader;
    logic [HND_W-1:0]    handle;
    logic                shift_if_full;

    modport source (output valid, command, reader, handle, shift_if_full, input ready);
    modport sink   (input valid, command, reader, handle, shift_if_full, output ready);
endinterface

interface pdq_out_if import pdq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HND_W-1:0]    popped;
    logic                dropped_valid;
    logic [HND_W-1:0]    dropped;
    logic [COUNT_W-1:0]  count;
    logic                last;

    modport source (output valid, status, popped, dropped_valid, dropped, count, last,
                    input ready);
    modport sink   (input valid, status, popped, dropped_valid, dropped, count, last,
                    output ready);
endinterface

### sv/pdq_ctrl.sv
module pdq_ctrl import pdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                // one result per step; clear keeps stepping until its last entry
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (!i_status.more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### sv/pdq_datapath.sv
module pdq_datapath import pdq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [READER_W-1:0] i_reader,
    input  logic [HND_W-1:0]    i_handle,
    input  logic                i_shift_if_full,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    pdq_out_if.source           o_rsp
);

    logic [HND_W-1:0]  r_mem [NUM_ENTRIES];
    logic [HND_W-1:0]  r_rd_data;
    logic [CNT_W-1:0]  r_count [NUM_READERS];
    logic [PTR_W-1:0]  r_head  [NUM_READERS];

    // transaction in progress
    t_cmd              r_cmd;
    logic [CH_W-1:0]   r_ch;
    logic              r_good;
    logic              r_shift;
    logic [HND_W-1:0]  r_hnd;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic [PTR_W-1:0]  r_head_l;
    logic [PTR_W-1:0]  r_rptr;

    // result register
    logic              r_o_valid;
    t_status           r_o_status;
    logic [HND_W-1:0]  r_o_popped;
    logic              r_o_dv;
    logic [HND_W-1:0]  r_o_dropped;
    logic [COUNT_W-1:0] r_o_count;
    logic              r_o_last;

    // accept side
    logic              in_good;
    logic [CH_W-1:0]   in_ch;
    logic [CNT_W-1:0]  in_n;
    logic [PTR_W-1:0]  in_head;
    logic [PTR_W-1:0]  in_rptr;

    // step side
    t_status           n_status;
    logic [HND_W-1:0]  n_popped;
    logic              n_dv;
    logic [HND_W-1:0]  n_dropped;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  n_rcount;
    logic              n_last;
    logic              is_full;
    logic              we;
    logic [PTR_W-1:0]  wptr;
    logic              upd;
    logic [CNT_W-1:0]  new_cnt;
    logic [PTR_W-1:0]  new_head;
    logic              more;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    always_comb begin
        in_good = (i_reader != '0) && (i_reader <= READER_W'(NUM_READERS));
        in_ch   = in_good ? CH_W'(i_reader - READER_W'(1)) : '0;
        in_n    = in_good ? r_count[in_ch] : '0;
        in_head = r_head[in_ch];
        // push_front touches the slot before head: new head, or the tail when full
        in_rptr = (t_cmd'(i_command) == CMD_PUSH_FRONT) ? ptr_dec(in_head) : in_head;
    end

    always_comb begin
        is_full   = (r_n == CNT_W'(QUEUE_DEPTH));
        n_status  = STAT_OK;
        n_popped  = '0;
        n_dv      = 1'b0;
        n_dropped = '0;
        n_cnt     = r_n;
        n_last    = 1'b1;
        we        = 1'b0;
        wptr      = r_rptr;
        upd       = 1'b0;
        new_cnt   = r_n;
        new_head  = r_head_l;
        more      = 1'b0;
        unique case (r_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (r_hnd == '0) begin
                    n_status = STAT_NULL;
                end else if (!r_good) begin
                    n_status  = STAT_BADCH;
                    n_dv      = 1'b1;
                    n_dropped = r_hnd;
                    n_cnt     = '0;
                end else if (is_full && !r_shift) begin
                    n_status  = STAT_FULL;
                    n_dv      = 1'b1;
                    n_dropped = r_hnd;
                end else begin
                    we  = 1'b1;
                    upd = 1'b1;
                    if (is_full) begin
                        n_dv      = 1'b1;
                        n_dropped = r_rd_data;
                    end else begin
                        new_cnt = r_n + CNT_W'(1);
                    end
                    if (r_cmd == CMD_PUSH_BACK) begin
                        if (is_full) begin
                            new_head = ptr_inc(r_head_l);
                        end else begin
                            wptr = ptr_add(r_head_l, r_n);
                        end
                    end else begin
                        new_head = r_rptr;
                    end
                    n_cnt = new_cnt;
                end
            end
            CMD_POP: begin
                if (!r_good) begin
                    n_status = STAT_BADCH;
                end else if (r_n == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_popped = r_rd_data;
                    new_cnt  = r_n - CNT_W'(1);
                    new_head = ptr_inc(r_head_l);
                    upd      = 1'b1;
                    n_cnt    = new_cnt;
                end
            end
            CMD_CLEAR: begin
                if (!r_good) begin
                    n_status = STAT_BADCH;
                end else if (r_n != '0) begin
                    n_dv      = 1'b1;
                    n_dropped = r_rd_data;
                    n_cnt     = '0;
                    n_last    = (r_idx == r_n - CNT_W'(1));
                    if (n_last) begin
                        upd     = 1'b1;
                        new_cnt = '0;
                    end else begin
                        more = 1'b1;
                    end
                end
            end
            default: begin
                n_status = r_good ? STAT_OK : STAT_BADCH;
            end
        endcase
        n_rcount = n_cnt;
    end

    assign re    = i_cmd.accept || (i_cmd.step && more);
    assign raddr = i_cmd.accept ? mem_addr(in_ch, in_rptr) : mem_addr(r_ch, ptr_inc(r_rptr));

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && we) begin
            r_mem[mem_addr(r_ch, wptr)] <= r_hnd;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= t_cmd'(i_command);
            r_ch     <= in_ch;
            r_good   <= in_good;
            r_shift  <= i_shift_if_full;
            r_hnd    <= i_handle & HANDLE_MASK;
            r_n      <= in_n;
            r_head_l <= in_head;
            r_rptr   <= in_rptr;
            r_idx    <= '0;
        end else if (i_cmd.step && more) begin
            r_idx  <= r_idx + CNT_W'(1);
            r_rptr <= ptr_inc(r_rptr);
        end
        if (i_cmd.step) begin
            r_o_status  <= n_status;
            r_o_popped  <= n_popped;
            r_o_dv      <= n_dv;
            r_o_dropped <= n_dropped;
            r_o_count   <= COUNT_W'(n_rcount);
            r_o_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_READERS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
            end
        end else begin
            if (i_cmd.step) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.step && upd) begin
                r_count[r_ch] <= new_cnt;
                r_head[r_ch]  <= new_head;
            end
        end
    end

    assign o_status.more     = more;
    assign o_status.out_free = !r_o_valid || o_rsp.ready;

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.popped        = r_o_popped;
    assign o_rsp.dropped_valid = r_o_dv;
    assign o_rsp.dropped       = r_o_dropped;
    assign o_rsp.count         = r_o_count;
    assign o_rsp.last          = r_o_last;

endmodule

### sv/per_channel_bounded_deque_core.sv
// Per-channel bounded deque of message handles, kept as one circular buffer per
// channel in a single-port-write, registered-read handle RAM, with a head
// pointer and entry count per channel in flops. The accept cycle launches the
// RAM read of the head slot (or the slot before it for push_front); the result
// step, taken once the output register is free, writes back, updates
// head/count and loads the result register. Clear on a channel holding n
// entries gives n results, one RAM read per entry. One command is in flight at
// a time; the next is taken while the last result still sits in the output
// register, and a stalled output holds the block in its result state. No
// clearing pass after reset: only the counts, head pointers, state and output
// valid reset, and RAM data beyond the counts is never used.
module per_channel_bounded_deque_core import pdq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdq_in_if.sink    i_req,
    pdq_out_if.source o_rsp
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    pdq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_req.command),
        .i_reader        (i_req.reader),
        .i_handle        (i_req.handle),
        .i_shift_if_full (i_req.shift_if_full),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_rsp           (o_rsp)
    );

    // one command at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("command accepted while another is in progress");

    // only clear produces non-final results, and those always carry a drop
    a_nonlast_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.last) |-> (o_rsp.dropped_valid && o_rsp.count == '0))
        else $error("non-final result that is not a clear drop");

    // empty pop returns nothing
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_EMPTY)
            |-> (o_rsp.popped == '0 && !o_rsp.dropped_valid && o_rsp.count == '0))
        else $error("empty status with payload");

endmodule

### bench/per_channel_bounded_deque_core_test.sv
module per_channel_bounded_deque_core_test;
    import pdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [HND_W-1:0] HND_MASK = HND_W'((64'd1 << HANDLE_WIDTH) - 1);

    // unused command codes behave as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    typedef struct packed {
        t_status            status;
        logic [HND_W-1:0]   popped;
        logic               dropped_valid;
        logic [HND_W-1:0]   dropped;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_deque_rsp;

    logic clk = 1'b0;
    logic rst_n;

    pdq_in_if  req_if ();
    pdq_out_if rsp_if ();

    per_channel_bounded_deque_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of every channel's deque, head at index 0
    logic [HND_W-1:0] deque_mem [NUM_READERS][QUEUE_DEPTH];
    int               deque_len [NUM_READERS];
    t_deque_rsp       pending_rsp[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    task automatic deque_predict(input logic [CMD_W-1:0] cmd, input logic [READER_W-1:0] rd,
                                 input logic [HND_W-1:0] hnd_in, input logic shift);
        logic [HND_W-1:0] hnd;
        logic             good;
        int               ch;
        int               n;
        int               i;
        t_deque_rsp       r;
        hnd  = hnd_in & HND_MASK;
        good = (int'(rd) >= 1) && (int'(rd) <= NUM_READERS);
        ch   = good ? int'(rd) - 1 : 0;
        n    = good ? deque_len[ch] : 0;
        r    = '{status: STAT_OK, popped: '0, dropped_valid: 1'b0, dropped: '0,
                 count: '0, last: 1'b1};
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
            if (hnd == '0) begin
                // null check wins over the channel check
                r.status = STAT_NULL;
                r.count  = COUNT_W'(n);
            end else if (!good) begin
                r.status        = STAT_BADCH;
                r.dropped_valid = 1'b1;
                r.dropped       = hnd;
            end else if (n >= QUEUE_DEPTH && !shift) begin
                r.status        = STAT_FULL;
                r.dropped_valid = 1'b1;
                r.dropped       = hnd;
                r.count         = COUNT_W'(n);
            end else if (cmd == CMD_PUSH_FRONT) begin
                if (n >= QUEUE_DEPTH) begin
                    n               = QUEUE_DEPTH;
                    r.dropped_valid = 1'b1;
                    r.dropped       = deque_mem[ch][n-1];
                end else begin
                    n++;
                end
                for (i = n - 1; i >= 1; i--) begin
                    deque_mem[ch][i] = deque_mem[ch][i-1];
                end
                deque_mem[ch][0] = hnd;
                deque_len[ch]    = n;
                r.count          = COUNT_W'(n);
            end else begin
                if (n >= QUEUE_DEPTH) begin
                    n               = QUEUE_DEPTH;
                    r.dropped_valid = 1'b1;
                    r.dropped       = deque_mem[ch][0];
                    for (i = 0; i + 1 < n; i++) begin
                        deque_mem[ch][i] = deque_mem[ch][i+1];
                    end
                    deque_mem[ch][n-1] = hnd;
                end else begin
                    deque_mem[ch][n] = hnd;
                    n++;
                end
                deque_len[ch] = n;
                r.count       = COUNT_W'(n);
            end
            pending_rsp.push_back(r);
        end else if (cmd == CMD_POP) begin
            if (!good) begin
                r.status = STAT_BADCH;
            end else if (n == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.popped = deque_mem[ch][0];
                for (i = 0; i + 1 < n; i++) begin
                    deque_mem[ch][i] = deque_mem[ch][i+1];
                end
                n--;
                deque_len[ch] = n;
                r.count       = COUNT_W'(n);
            end
            pending_rsp.push_back(r);
        end else if (cmd == CMD_CLEAR) begin
            if (!good) begin
                r.status = STAT_BADCH;
                pending_rsp.push_back(r);
            end else if (n == 0) begin
                pending_rsp.push_back(r);
            end else begin
                // one result per stored handle, head first
                for (i = 0; i < n; i++) begin
                    r.dropped_valid = 1'b1;
                    r.dropped       = deque_mem[ch][i];
                    r.last          = (i == n - 1);
                    pending_rsp.push_back(r);
                end
                deque_len[ch] = 0;
            end
        end else begin
            r.status = good ? STAT_OK : STAT_BADCH;
            r.count  = COUNT_W'(n);
            pending_rsp.push_back(r);
        end
    endtask

    // one transaction on the request channel, with bursty idle gaps
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [READER_W-1:0] rd,
                            input logic [HND_W-1:0] hnd, input logic shift);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        deque_predict(cmd, rd, hnd, shift);
        req_if.valid         <= 1'b1;
        req_if.command       <= cmd;
        req_if.reader        <= rd;
        req_if.handle        <= hnd;
        req_if.shift_if_full <= shift;
        do begin
            @(posedge clk);
        end while (req_if.ready !== 1'b1);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        t_deque_rsp exp_rsp;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0h", $time,
                         rsp_if.status);
                error_count++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                check_field("status", 32'(exp_rsp.status), 32'(rsp_if.status));
                check_field("popped", 32'(exp_rsp.popped), 32'(rsp_if.popped));
                check_field("dropped_valid", 32'(exp_rsp.dropped_valid),
                            32'(rsp_if.dropped_valid));
                check_field("dropped", 32'(exp_rsp.dropped), 32'(rsp_if.dropped));
                check_field("count", 32'(exp_rsp.count), 32'(rsp_if.count));
                check_field("last", 32'(exp_rsp.last), 32'(rsp_if.last));
            end
        end
    end

    // receiver back-pressure: randomly chosen stall modes
    initial begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                0: begin
                    rsp_if.ready <= 1'b1;
                end
                1: begin
                    rsp_if.ready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    rsp_if.ready <= ((mode_left % 7) < 2);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(CMD_PUSH_BACK, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_PUSH_FRONT, 8'd0, 16'h0000, 1'b1);
        send_cmd(CMD_PUSH_BACK, 8'd0, 16'hFFFF, 1'b0);
        send_cmd(CMD_PUSH_FRONT, 8'd255, 16'h0001, 1'b1);
        send_cmd(CMD_POP, 8'(NUM_READERS + 1), 16'h0000, 1'b0);
        send_cmd(CMD_CLEAR, 8'd0, 16'h0000, 1'b0);
        send_cmd(CMD_QUERY, 8'd255, 16'h0000, 1'b0);
        send_cmd(CMD_POP, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_CLEAR, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_PUSH_BACK, 8'd1, 16'h0001, 1'b0);
        send_cmd(CMD_PUSH_FRONT, 8'd1, 16'hFFFF, 1'b0);
        send_cmd(CMD_PUSH_BACK, 8'(NUM_READERS), 16'h8000, 1'b1);
        send_cmd(CMD_QUERY, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_SPARE_LO, 8'd1, 16'h1234, 1'b1);
        send_cmd(CMD_SPARE_MID, 8'(NUM_READERS), 16'h0000, 1'b0);
        send_cmd(CMD_SPARE_HI, 8'd0, 16'hFFFF, 1'b1);
        send_cmd(CMD_POP, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_CLEAR, 8'd1, 16'h0000, 1'b0);
        send_cmd(CMD_PUSH_BACK, 8'(NUM_READERS), 16'h7FFF, 1'b0);
        send_cmd(CMD_CLEAR, 8'(NUM_READERS), 16'h0000, 1'b0);
        send_cmd(CMD_POP, 8'(NUM_READERS), 16'h0000, 1'b0);
    endtask

    // fill a channel, push past full both ways, then pop up to three and, in even rounds, clear it
    task automatic test_fill_overflow();
        int                   round;
        int                   k;
        logic [READER_W-1:0]  rd;
        logic [CMD_W-1:0]     push_cmd;
        for (round = 0; round < 4; round++) begin
            rd = 8'($urandom_range(1, NUM_READERS));
            while (deque_len[int'(rd) - 1] < QUEUE_DEPTH) begin
                push_cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                send_cmd(push_cmd, rd, 16'($urandom_range(1, 16'hFFFF)), 1'($urandom));
            end
            send_cmd(CMD_QUERY, rd, 16'($urandom), 1'($urandom));
            for (k = 0; k < 6; k++) begin
                push_cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                send_cmd(push_cmd, rd, 16'($urandom_range(1, 16'hFFFF)), 1'($urandom));
            end
            repeat ($urandom_range(0, 3)) begin
                send_cmd(CMD_POP, rd, 16'($urandom), 1'($urandom));
            end
            if (round % 2 == 0) begin
                send_cmd(CMD_CLEAR, rd, 16'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int                  roll;
        logic [READER_W-1:0] rd;
        logic [HND_W-1:0]    hnd;
        logic                shift;
        repeat (280) begin
            roll  = $urandom_range(0, 99);
            rd    = 8'($urandom_range(1, NUM_READERS));
            hnd   = 16'($urandom_range(1, 16'hFFFF));
            shift = 1'($urandom);
            if (roll < 30) begin
                send_cmd(CMD_PUSH_BACK, rd, hnd, shift);
            end else if (roll < 55) begin
                send_cmd(CMD_PUSH_FRONT, rd, hnd, shift);
            end else if (roll < 80) begin
                send_cmd(CMD_POP, rd, hnd, shift);
            end else if (roll < 83) begin
                send_cmd(CMD_CLEAR, rd, hnd, shift);
            end else if (roll < 90) begin
                send_cmd(CMD_QUERY, rd, hnd, shift);
            end else if (roll < 94) begin
                rd = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(NUM_READERS + 1, 255));
                send_cmd(CMD_W'($urandom_range(0, 7)), rd, hnd, shift);
            end else if (roll < 97) begin
                rd = 8'($urandom_range(0, 255));
                send_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rd, '0, shift);
            end else begin
                rd = 8'($urandom_range(0, 255));
                send_cmd(CMD_W'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI))), rd,
                         hnd, shift);
            end
        end
    endtask

    initial begin
        int ch;
        for (ch = 0; ch < NUM_READERS; ch++) begin
            deque_len[ch] = 0;
        end
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.command       <= CMD_PUSH_BACK;
        req_if.reader        <= '0;
        req_if.handle        <= '0;
        req_if.shift_if_full <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_overflow();
        test_random_traffic();

        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### per_channel_bounded_deque_core.f
sv/pdq_pkg.sv
sv/pdq_if.sv
sv/pdq_ctrl.sv
sv/pdq_datapath.sv
sv/per_channel_bounded_deque_core.sv
bench/per_channel_bounded_deque_core_test.sv
